/* src/nsp_pkg.sv */
// Shared types and codes of the nested section profiler.
`default_nettype none
package nsp_pkg;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BAD_ID = 2'd1,
    ERR_FULL   = 2'd2,
    ERR_EMPTY  = 2'd3
  } err_t;

  localparam logic CFG_EMA_WEIGHT = 1'b0;
  localparam logic CFG_SECTIONS   = 1'b1;

  localparam logic [15:0] EMA_WEIGHT_RESET = 16'd55706;

  typedef struct packed {
    op_t         op;
    logic [4:0]  section_id;
    logic [3:0]  bucket_index;
    logic [31:0] timestamp;
  } in_word_t;

  typedef struct packed {
    err_t        error;
    logic [4:0]  section_out;
    logic [31:0] elapsed;
    logic [31:0] call_count;
    logic [47:0] total_exec;
    logic [47:0] total_child;
    logic [47:0] total_gap;
    logic [31:0] exec_average;
    logic [31:0] gap_average;
    logic [31:0] exec_bin_count;
    logic [31:0] gap_bin_count;
  } out_word_t;

  // Command handed from the front end to the back end.
  typedef struct packed {
    in_word_t item;
    logic     id_bad;
  } cmd_t;

endpackage
`default_nettype wire

/* src/nsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* src/nsp_queue.sv */
// Two-entry command queue between the front end and the back end.
`default_nettype none
module nsp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire nsp_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               avail,
  output nsp_pkg::cmd_t      pop_cmd
);

  nsp_pkg::cmd_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign avail   = (count != 2'd0);
  assign pop_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* src/nsp_front.sv */
// Front end: accepts input words and checks the section id.
`default_nettype none
module nsp_front #(
  parameter int SECTIONS = 32
) (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nsp_pkg::in_word_t in_word,
  input  wire logic [5:0]        sections_in_use,
  input  wire logic              init_busy,
  input  wire logic              q_full,
  output logic                   push,
  output nsp_pkg::cmd_t          push_cmd
);

  logic [8:0] sid_ext;

  assign sid_ext  = 9'(in_word.section_id);
  assign in_stall = q_full | init_busy;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    push_cmd        = '0;
    push_cmd.item   = in_word;
    push_cmd.id_bad = !((sid_ext < 9'(sections_in_use)) && (sid_ext < 9'(SECTIONS)));
  end

endmodule
`default_nettype wire

/* src/nsp_back.sv */
// Back end: sequencer that updates the statistics stores and builds results.
`default_nettype none
module nsp_back #(
  parameter int SECTIONS     = 32,
  parameter int HIST_BINS    = 10,
  parameter int HIST_SPAN_US = 1000000,
  parameter int NEST_DEPTH   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [15:0]   ema_weight,
  input  wire logic          q_avail,
  input  wire nsp_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               init_busy,
  output logic               out_valid,
  input  wire logic          out_stall,
  output nsp_pkg::out_word_t out_word
);

  localparam int SW     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int HDEPTH = SECTIONS * HIST_BINS;
  localparam int HW     = $clog2(HDEPTH);
  localparam int BW     = $clog2(HIST_BINS);
  localparam int DW     = $clog2(NEST_DEPTH + 1);
  localparam int PW     = $clog2(NEST_DEPTH);
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  // ---------------- elaboration-time bucket bounds ----------------
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bv;
    v   = val;
    res = '0;
    bv  = 64'd1 << 62;
    while (bv > v) bv = bv >> 2;
    while (bv != 0) begin
      if (v >= res + bv) begin
        v   = v - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] y);
    logic [63:0] p;
    p = (y * y) >> 30;
    p = (p * y) >> 30;
    p = (p * y) >> 30;
    p = (p * y) >> 30;
    return p;
  endfunction

  function automatic logic [63:0] bound_calc(input int k);
    logic [63:0] b4;
    logic [63:0] kk;
    logic [63:0] x;
    logic [63:0] q;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] a;
    kk = 64'(k);
    b4 = 64'(HIST_BINS) * 64'(HIST_BINS) * 64'(HIST_BINS) * 64'(HIST_BINS);
    x  = udiv(kk << 30, 64'(HIST_BINS));
    q  = isqrt(isqrt(x << 30) << 30);
    lo = '0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      if (pow5(mid) <= q) lo = mid;
      else hi = mid - 64'd1;
    end
    a = 64'(HIST_SPAN_US) * (kk * kk * kk * kk);
    return udiv(a * (lo >> 14), b4 << 16);
  endfunction

  logic [31:0] bound [HIST_BINS];

  for (genvar k = 0; k < HIST_BINS; k++) begin : g_bound
    localparam logic [63:0] BND = bound_calc(k + 1);
    assign bound[k] = BND[31:0];
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, a} + 49'(d);
    return s[48] ? MAX48 : s[47:0];
  endfunction

  // ---------------- sequencer ----------------
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EN_RD, S_EN_DAT, S_EX_POP, S_EX_TOP, S_EX_PAR, S_EX_DAT,
    S_BIN, S_HRD, S_UPD, S_RPT, S_RPT2, S_SWEEP
  } state_t;

  state_t        state;
  nsp_pkg::cmd_t cmd;
  logic [SW-1:0] rid;
  logic [SW-1:0] par;
  logic          has_par;
  logic [31:0]   samp;
  logic [BW-1:0] bin;
  logic [31:0]   calls_q;
  logic [47:0]   tot_q;
  logic [31:0]   avg_q;
  logic [47:0]   prod_a;
  logic [48:0]   prod_b;
  logic [DW-1:0] depth;
  logic [HW-1:0] idx;
  logic [31:0]   clr_time;
  logic          emit;

  logic [BW-1:0] bin_c;
  logic          bk_ok;
  logic [BW-1:0] hbin;
  logic [HW-1:0] hist_addr;
  logic [49:0]   ema_sum;
  logic [31:0]   ema_val;
  logic          sweep;
  logic          store_sweep;
  logic          is_enter;
  logic          upd;

  logic [31:0] calls_rd;
  logic [47:0] etot_rd;
  logic [47:0] ctot_rd;
  logic [47:0] gtot_rd;
  logic [31:0] last_rd;
  logic [31:0] eavg_rd;
  logic [31:0] gavg_rd;
  logic [31:0] ehist_rd;
  logic [31:0] ghist_rd;
  logic [SW+31:0] stk_rd;

  logic [SW-1:0] st_wa;
  logic [SW-1:0] ctot_ra;
  logic [SW-1:0] ctot_wa;
  logic [HW-1:0] hist_wa;
  logic [PW-1:0] stk_ra;
  logic          calls_we;
  logic          etot_we;
  logic          ctot_we;
  logic          gtot_we;
  logic          last_we;
  logic          eavg_we;
  logic          gavg_we;
  logic          ehist_we;
  logic          ghist_we;
  logic          stk_we;
  logic [31:0]   calls_wd;
  logic [47:0]   etot_wd;
  logic [47:0]   ctot_wd;
  logic [47:0]   gtot_wd;
  logic [31:0]   last_wd;
  logic [31:0]   eavg_wd;
  logic [31:0]   gavg_wd;
  logic [31:0]   ehist_wd;
  logic [31:0]   ghist_wd;

  always_comb begin
    bin_c = BW'(HIST_BINS - 1);
    for (int i = HIST_BINS - 1; i >= 0; i--) begin
      if (samp < bound[i]) bin_c = BW'(i);
    end
  end

  assign bk_ok     = 6'(cmd.item.bucket_index) < 6'(HIST_BINS);
  assign hbin      = (state == S_RPT) ? (bk_ok ? BW'(cmd.item.bucket_index) : '0) : bin;
  assign hist_addr = HW'(rid) * HW'(HIST_BINS) + HW'(hbin);
  assign ema_sum   = 50'(prod_a) + 50'(prod_b) + 50'd32768;
  assign ema_val   = ema_sum[47:16];
  assign sweep       = (state == S_SWEEP);
  assign store_sweep = sweep && (idx < HW'(SECTIONS));
  assign is_enter  = (cmd.item.op == nsp_pkg::OP_ENTER);
  assign upd       = (state == S_UPD);
  assign init_busy = sweep && !emit;
  assign q_pop     = (state == S_IDLE) && q_avail && !out_valid;

  always_comb begin
    st_wa    = sweep ? idx[SW-1:0] : rid;
    ctot_wa  = sweep ? idx[SW-1:0] : par;
    ctot_ra  = (state == S_HRD && !is_enter) ? par : rid;
    hist_wa  = sweep ? idx : hist_addr;
    stk_ra   = (state == S_EX_TOP) ? PW'(depth - DW'(1)) : PW'(depth);

    calls_we = store_sweep || (upd && is_enter);
    last_we  = store_sweep || (upd && is_enter);
    gtot_we  = store_sweep || (upd && is_enter && calls_q > 32'd1);
    gavg_we  = gtot_we;
    ghist_we = sweep || (upd && is_enter && calls_q > 32'd1);
    etot_we  = store_sweep || (upd && !is_enter);
    eavg_we  = etot_we;
    ehist_we = sweep || (upd && !is_enter);
    ctot_we  = store_sweep || (upd && !is_enter && has_par);
    stk_we   = upd && is_enter;

    calls_wd = sweep ? '0 : calls_q;
    last_wd  = sweep ? clr_time : cmd.item.timestamp;
    gtot_wd  = sweep ? '0 : sat_add(tot_q, samp);
    gavg_wd  = sweep ? '0 : ((calls_q == 32'd2) ? samp : ema_val);
    ghist_wd = sweep ? '0 : sat_inc(ghist_rd);
    etot_wd  = sweep ? '0 : sat_add(tot_q, samp);
    eavg_wd  = sweep ? '0 : ((calls_q == 32'd1) ? samp : ema_val);
    ehist_wd = sweep ? '0 : sat_inc(ehist_rd);
    ctot_wd  = sweep ? '0 : sat_add(ctot_rd, samp);
  end

  nsp_ram #(.WIDTH(32), .DEPTH(SECTIONS)) u_calls (.clk(clk), .wr_en(calls_we),
    .wr_addr(st_wa), .wr_data(calls_wd), .rd_addr(rid), .rd_data(calls_rd));
  nsp_ram #(.WIDTH(48), .DEPTH(SECTIONS)) u_etot (.clk(clk), .wr_en(etot_we),
    .wr_addr(st_wa), .wr_data(etot_wd), .rd_addr(rid), .rd_data(etot_rd));
  nsp_ram #(.WIDTH(48), .DEPTH(SECTIONS)) u_ctot (.clk(clk), .wr_en(ctot_we),
    .wr_addr(ctot_wa), .wr_data(ctot_wd), .rd_addr(ctot_ra), .rd_data(ctot_rd));
  nsp_ram #(.WIDTH(48), .DEPTH(SECTIONS)) u_gtot (.clk(clk), .wr_en(gtot_we),
    .wr_addr(st_wa), .wr_data(gtot_wd), .rd_addr(rid), .rd_data(gtot_rd));
  nsp_ram #(.WIDTH(32), .DEPTH(SECTIONS)) u_last (.clk(clk), .wr_en(last_we),
    .wr_addr(st_wa), .wr_data(last_wd), .rd_addr(rid), .rd_data(last_rd));
  nsp_ram #(.WIDTH(32), .DEPTH(SECTIONS)) u_eavg (.clk(clk), .wr_en(eavg_we),
    .wr_addr(st_wa), .wr_data(eavg_wd), .rd_addr(rid), .rd_data(eavg_rd));
  nsp_ram #(.WIDTH(32), .DEPTH(SECTIONS)) u_gavg (.clk(clk), .wr_en(gavg_we),
    .wr_addr(st_wa), .wr_data(gavg_wd), .rd_addr(rid), .rd_data(gavg_rd));
  nsp_ram #(.WIDTH(32), .DEPTH(HDEPTH)) u_ehist (.clk(clk), .wr_en(ehist_we),
    .wr_addr(hist_wa), .wr_data(ehist_wd), .rd_addr(hist_addr), .rd_data(ehist_rd));
  nsp_ram #(.WIDTH(32), .DEPTH(HDEPTH)) u_ghist (.clk(clk), .wr_en(ghist_we),
    .wr_addr(hist_wa), .wr_data(ghist_wd), .rd_addr(hist_addr), .rd_data(ghist_rd));
  nsp_ram #(.WIDTH(SW + 32), .DEPTH(NEST_DEPTH)) u_stack (.clk(clk), .wr_en(stk_we),
    .wr_addr(PW'(depth)), .wr_data({rid, cmd.item.timestamp}), .rd_addr(stk_ra),
    .rd_data(stk_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      idx       <= '0;
      emit      <= 1'b0;
      clr_time  <= '0;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd   <= q_cmd;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          rid <= SW'(cmd.item.section_id);
          unique case (cmd.item.op)
            nsp_pkg::OP_CLEAR: begin
              idx      <= '0;
              emit     <= 1'b1;
              clr_time <= cmd.item.timestamp;
              state    <= S_SWEEP;
            end
            nsp_pkg::OP_READ: begin
              if (cmd.id_bad) begin
                out_word             <= '0;
                out_word.error       <= nsp_pkg::ERR_BAD_ID;
                out_word.section_out <= cmd.item.section_id;
                out_valid            <= 1'b1;
                state                <= S_IDLE;
              end else begin
                state <= S_RPT;
              end
            end
            nsp_pkg::OP_ENTER: begin
              if (cmd.id_bad || depth == DW'(NEST_DEPTH)) begin
                out_word             <= '0;
                out_word.error       <= cmd.id_bad ? nsp_pkg::ERR_BAD_ID : nsp_pkg::ERR_FULL;
                out_word.section_out <= cmd.item.section_id;
                out_valid            <= 1'b1;
                state                <= S_IDLE;
              end else begin
                state <= S_EN_RD;
              end
            end
            nsp_pkg::OP_EXIT: begin
              if (depth == '0) begin
                out_word       <= '0;
                out_word.error <= nsp_pkg::ERR_EMPTY;
                out_valid      <= 1'b1;
                state          <= S_IDLE;
              end else begin
                depth <= depth - DW'(1);
                state <= S_EX_POP;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_EN_RD: state <= S_EN_DAT;
        S_EN_DAT: begin
          calls_q <= sat_inc(calls_rd);
          samp    <= cmd.item.timestamp - last_rd;
          tot_q   <= gtot_rd;
          avg_q   <= gavg_rd;
          state   <= S_BIN;
        end
        S_EX_POP: state <= S_EX_TOP;
        S_EX_TOP: begin
          rid   <= stk_rd[SW+31:32];
          samp  <= cmd.item.timestamp - stk_rd[31:0];
          state <= S_EX_PAR;
        end
        S_EX_PAR: begin
          par     <= stk_rd[SW+31:32];
          has_par <= (depth != '0);
          state   <= S_EX_DAT;
        end
        S_EX_DAT: begin
          calls_q <= calls_rd;
          tot_q   <= etot_rd;
          avg_q   <= eavg_rd;
          state   <= S_BIN;
        end
        S_BIN: begin
          bin    <= bin_c;
          prod_a <= avg_q * ema_weight;
          prod_b <= samp * (17'h10000 - {1'b0, ema_weight});
          state  <= S_HRD;
        end
        S_HRD: state <= S_UPD;
        S_UPD: begin
          if (is_enter) begin
            depth <= depth + DW'(1);
          end
          state <= S_RPT;
        end
        S_RPT: state <= S_RPT2;
        S_RPT2: begin
          out_word.error          <= nsp_pkg::ERR_NONE;
          out_word.section_out    <= 5'(rid);
          out_word.elapsed        <= (cmd.item.op == nsp_pkg::OP_EXIT) ? samp : '0;
          out_word.call_count     <= calls_rd;
          out_word.total_exec     <= etot_rd;
          out_word.total_child    <= ctot_rd;
          out_word.total_gap      <= gtot_rd;
          out_word.exec_average   <= eavg_rd;
          out_word.gap_average    <= gavg_rd;
          out_word.exec_bin_count <= bk_ok ? ehist_rd : '0;
          out_word.gap_bin_count  <= bk_ok ? ghist_rd : '0;
          out_valid               <= 1'b1;
          state                   <= S_IDLE;
        end
        S_SWEEP: begin
          if (idx == HW'(HDEPTH - 1)) begin
            if (emit) begin
              out_word  <= '0;
              out_valid <= 1'b1;
            end
            emit  <= 1'b0;
            state <= S_IDLE;
          end else begin
            idx <= idx + HW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(NEST_DEPTH))
    else $error("stack depth beyond nesting limit");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && !init_busy)
    else $error("command taken outside idle");

  a_pop_decode: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_DECODE))
    else $error("taken command not decoded");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RPT2) |-> !out_valid)
    else $error("result would overwrite a pending word");
`endif

endmodule
`default_nettype wire

/* src/nested_section_profiler_core.sv */
// Top level of the nested section profiler: configuration registers and wiring.
//
//  channel   direction  handshake          word
//  in        into       in_valid/in_stall  in_word (op, section id, bucket, timestamp)
//  out       out of     out_valid/out_stall out_word (error, section and statistics)
//  cfg       into       cfg_valid/cfg_ready cfg_index, cfg_data
//
// A read, an enter and an exit each pass through the back end's single sequencer, which
// walks the statistics RAMs with one registered read per step.
// A clear sweeps all SECTIONS*HIST_BINS histogram entries, one per cycle.
// After reset the same sweep zeroes the RAMs; input words are stalled during it while
// configuration writes are taken as usual.
// A two-word queue lets the front end keep taking words while the back end works, and
// an output register holds a finished result until it is taken; the next command is
// fetched only once that register is free.
`default_nettype none
module nested_section_profiler_core #(
  parameter int SECTIONS     = 32,
  parameter int HIST_BINS    = 10,
  parameter int HIST_SPAN_US = 1000000,
  parameter int NEST_DEPTH   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire nsp_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output nsp_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // Configuration registers.
  logic [15:0] ema_weight;
  logic [5:0]  sections_in_use;

  logic          init_busy;
  logic          q_full;
  logic          q_avail;
  logic          push;
  logic          q_pop;
  nsp_pkg::cmd_t push_cmd;
  nsp_pkg::cmd_t q_cmd;

  // Writes are always taken; the user only writes while the block is idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_weight      <= nsp_pkg::EMA_WEIGHT_RESET;
      sections_in_use <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nsp_pkg::CFG_EMA_WEIGHT: ema_weight      <= cfg_data;
        nsp_pkg::CFG_SECTIONS:   sections_in_use <= cfg_data[5:0];
        default:                 ema_weight      <= ema_weight;
      endcase
    end
  end

  // The front end checks the id against the configured section count.
  nsp_front #(.SECTIONS(SECTIONS)) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .sections_in_use(sections_in_use),
    .init_busy      (init_busy),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  nsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .avail   (q_avail),
    .pop_cmd (q_cmd)
  );

  // The back end owns the stack, the statistics RAMs and the output register.
  nsp_back #(
    .SECTIONS    (SECTIONS),
    .HIST_BINS   (HIST_BINS),
    .HIST_SPAN_US(HIST_SPAN_US),
    .NEST_DEPTH  (NEST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ema_weight(ema_weight),
    .q_avail   (q_avail),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

/* bench/nested_section_profiler_core_tb.sv */
// Self-checking bench of the nested section profiler core.
`timescale 1ns / 100ps
module nested_section_profiler_core_tb;

  localparam int SECTIONS = 32;
  localparam int HIST_BINS = 10;
  localparam int HIST_SPAN_US = 1000000;
  localparam int NEST_DEPTH = 16;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  nsp_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nsp_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  nested_section_profiler_core #(
    .SECTIONS(SECTIONS), .HIST_BINS(HIST_BINS),
    .HIST_SPAN_US(HIST_SPAN_US), .NEST_DEPTH(NEST_DEPTH)
  ) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of every per-section store and the stack.
  logic [15:0] gamma;
  logic [5:0]  live_sections;
  logic [31:0] calls [SECTIONS];
  logic [47:0] exec_sum [SECTIONS];
  logic [47:0] child_sum [SECTIONS];
  logic [47:0] gap_sum [SECTIONS];
  logic [31:0] last_enter [SECTIONS];
  logic [31:0] exec_ema [SECTIONS];
  logic [31:0] gap_ema [SECTIONS];
  logic [31:0] exec_hist [SECTIONS][HIST_BINS];
  logic [31:0] gap_hist [SECTIONS][HIST_BINS];
  logic [4:0]  nest_ids [NEST_DEPTH];
  logic [31:0] nest_start [NEST_DEPTH];
  int          nest_level;
  longint unsigned bucket_bound [HIST_BINS];

  nsp_pkg::in_word_t  pending_words [$];
  nsp_pkg::out_word_t expected_words [$];
  int  failures = 0;
  int  words_checked = 0;
  bit  idle_free = 1'b0;
  int  sent_words = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned fifth_power(longint unsigned y);
    longint unsigned p;
    p = (y * y) >> 30;
    p = (p * y) >> 30;
    p = (p * y) >> 30;
    return (p * y) >> 30;
  endfunction

  // Power-law bucket edges, built once with the same fixed-point recipe as the block.
  task automatic build_bucket_bounds();
    longint unsigned b4, x, q, lo, hi, mid, k;
    b4 = HIST_BINS * HIST_BINS * HIST_BINS * HIST_BINS;
    for (k = 1; k <= HIST_BINS; k++) begin
      x = (k << 30) / HIST_BINS;
      q = int_sqrt(int_sqrt(x << 30) << 30);
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (fifth_power(mid) <= q) lo = mid;
        else hi = mid - 1;
      end
      bucket_bound[k-1] = (longint'(HIST_SPAN_US) * (k * k * k * k) * (lo >> 14)) / (b4 << 16);
    end
  endtask

  function automatic int bucket_of(logic [31:0] t);
    for (int i = 0; i < HIST_BINS; i++)
      if (longint'(t) < bucket_bound[i]) return i;
    return HIST_BINS - 1;
  endfunction

  function automatic logic [31:0] bump32(logic [31:0] v);
    return (v == MAX32) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] add48(logic [47:0] a, logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, a} + d;
    return (s > {1'b0, MAX48}) ? MAX48 : s[47:0];
  endfunction

  function automatic logic [31:0] blend(logic [31:0] avg, logic [31:0] s);
    logic [63:0] acc;
    acc = 64'(avg) * gamma + 64'(s) * (32'd65536 - gamma) + 64'd32768;
    return acc[47:16];
  endfunction

  function automatic nsp_pkg::out_word_t section_report(int id, logic [31:0] el,
                                                        logic [3:0] bkt);
    nsp_pkg::out_word_t r;
    r = '0;
    r.error = nsp_pkg::ERR_NONE;
    r.section_out = id[4:0];
    r.elapsed = el;
    r.call_count = calls[id];
    r.total_exec = exec_sum[id];
    r.total_child = child_sum[id];
    r.total_gap = gap_sum[id];
    r.exec_average = exec_ema[id];
    r.gap_average = gap_ema[id];
    if (bkt < HIST_BINS) begin
      r.exec_bin_count = exec_hist[id][bkt];
      r.gap_bin_count = gap_hist[id][bkt];
    end
    return r;
  endfunction

  // Advances the predictor by one accepted word and returns the result it should produce.
  function automatic nsp_pkg::out_word_t profile_step(nsp_pkg::in_word_t w);
    nsp_pkg::out_word_t r;
    int sid, id, parent, b;
    logic [31:0] gap, el, c;
    bit id_ok;
    r = '0;
    sid = w.section_id;
    id_ok = (sid < live_sections);
    case (w.op)
      nsp_pkg::OP_ENTER: begin
        if (!id_ok) begin
          r.error = nsp_pkg::ERR_BAD_ID;
          r.section_out = w.section_id;
        end else if (nest_level >= NEST_DEPTH) begin
          r.error = nsp_pkg::ERR_FULL;
          r.section_out = w.section_id;
        end else begin
          c = bump32(calls[sid]);
          calls[sid] = c;
          if (c > 1) begin
            gap = w.timestamp - last_enter[sid];
            gap_sum[sid] = add48(gap_sum[sid], gap);
            gap_ema[sid] = (c == 2) ? gap : blend(gap_ema[sid], gap);
            b = bucket_of(gap);
            gap_hist[sid][b] = bump32(gap_hist[sid][b]);
          end
          nest_ids[nest_level] = w.section_id;
          nest_start[nest_level] = w.timestamp;
          nest_level++;
          last_enter[sid] = w.timestamp;
          r = section_report(sid, 32'd0, w.bucket_index);
        end
      end
      nsp_pkg::OP_EXIT: begin
        if (nest_level == 0) begin
          r.error = nsp_pkg::ERR_EMPTY;
        end else begin
          nest_level--;
          id = nest_ids[nest_level];
          el = w.timestamp - nest_start[nest_level];
          exec_sum[id] = add48(exec_sum[id], el);
          if (nest_level > 0) begin
            parent = nest_ids[nest_level-1];
            child_sum[parent] = add48(child_sum[parent], el);
          end
          exec_ema[id] = (calls[id] == 1) ? el : blend(exec_ema[id], el);
          b = bucket_of(el);
          exec_hist[id][b] = bump32(exec_hist[id][b]);
          r = section_report(id, el, w.bucket_index);
        end
      end
      nsp_pkg::OP_READ: begin
        if (!id_ok) begin
          r.error = nsp_pkg::ERR_BAD_ID;
          r.section_out = w.section_id;
        end else begin
          r = section_report(sid, 32'd0, w.bucket_index);
        end
      end
      default: begin
        for (int i = 0; i < SECTIONS; i++) begin
          calls[i] = '0; exec_sum[i] = '0; child_sum[i] = '0; gap_sum[i] = '0;
          exec_ema[i] = '0; gap_ema[i] = '0; last_enter[i] = w.timestamp;
          for (int j = 0; j < HIST_BINS; j++) begin
            exec_hist[i][j] = '0;
            gap_hist[i][j] = '0;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Driver: presents the oldest pending word, holding it while the block stalls.
  // The predictor runs at the accepting edge so expectations follow input order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(profile_step(in_word));
        void'(pending_words.pop_front());
        sent_words++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > (in_valid && !in_stall ? 0 : 0) &&
            (idle_free || $urandom_range(99) >= 22)) begin
          in_valid <= 1'b1;
          in_word <= pending_words[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin
    nsp_pkg::out_word_t exp_w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          failures++;
          $display("%0t: unexpected result word %h", $time, out_word);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.error !== out_word.error) begin
            failures++;
            $display("%0t: error exp %0d got %0d", $time, exp_w.error, out_word.error);
          end
          if (exp_w.section_out !== out_word.section_out) begin
            failures++;
            $display("%0t: section exp %0d got %0d", $time, exp_w.section_out,
                     out_word.section_out);
          end
          if (exp_w.elapsed !== out_word.elapsed) begin
            failures++;
            $display("%0t: elapsed exp %0d got %0d", $time, exp_w.elapsed, out_word.elapsed);
          end
          if (exp_w.call_count !== out_word.call_count) begin
            failures++;
            $display("%0t: calls exp %0d got %0d", $time, exp_w.call_count,
                     out_word.call_count);
          end
          if (exp_w.total_exec !== out_word.total_exec) begin
            failures++;
            $display("%0t: total exec exp %0d got %0d", $time, exp_w.total_exec,
                     out_word.total_exec);
          end
          if (exp_w.total_child !== out_word.total_child) begin
            failures++;
            $display("%0t: total child exp %0d got %0d", $time, exp_w.total_child,
                     out_word.total_child);
          end
          if (exp_w.total_gap !== out_word.total_gap) begin
            failures++;
            $display("%0t: total gap exp %0d got %0d", $time, exp_w.total_gap,
                     out_word.total_gap);
          end
          if (exp_w.exec_average !== out_word.exec_average) begin
            failures++;
            $display("%0t: exec avg exp %0d got %0d", $time, exp_w.exec_average,
                     out_word.exec_average);
          end
          if (exp_w.gap_average !== out_word.gap_average) begin
            failures++;
            $display("%0t: gap avg exp %0d got %0d", $time, exp_w.gap_average,
                     out_word.gap_average);
          end
          if (exp_w.exec_bin_count !== out_word.exec_bin_count) begin
            failures++;
            $display("%0t: exec bin exp %0d got %0d", $time, exp_w.exec_bin_count,
                     out_word.exec_bin_count);
          end
          if (exp_w.gap_bin_count !== out_word.gap_bin_count) begin
            failures++;
            $display("%0t: gap bin exp %0d got %0d", $time, exp_w.gap_bin_count,
                     out_word.gap_bin_count);
          end
        end
      end
      out_stall <= !idle_free && ($urandom_range(99) < 22);
    end
  end

  // Writes one register while nothing is in flight; the predictor copy follows at once.
  task automatic write_register(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == nsp_pkg::CFG_EMA_WEIGHT) gamma = value;
    else live_sections = value[5:0];
    cfg_valid <= 1'b0;
  endtask

  // Lets everything queued drain, then waits long enough for a clear sweep to finish.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SECTIONS * HIST_BINS + 20) @(posedge clk);
  endtask

  function automatic nsp_pkg::in_word_t make_word(nsp_pkg::op_t op, int sid, int bkt,
                                                  logic [31:0] ts);
    nsp_pkg::in_word_t w;
    w.op = op;
    w.section_id = sid[4:0];
    w.bucket_index = bkt[3:0];
    w.timestamp = ts;
    return w;
  endfunction

  // Random traffic: mostly balanced enter/exit nests with reads, some noise and clears.
  task automatic random_phase(int count, int id_span, bit far_times);
    logic [31:0] clock_us;
    int depth, pick;
    clock_us = $urandom;
    depth = 0;
    for (int n = 0; n < count; n++) begin
      clock_us += far_times ? $urandom : $urandom_range(1, 300000);
      pick = $urandom_range(99);
      if (pick < 40 && depth < NEST_DEPTH + 1) begin
        pending_words.push_back(make_word(nsp_pkg::OP_ENTER, $urandom_range(id_span),
                                          $urandom_range(15), clock_us));
        depth++;
      end else if (pick < 75) begin
        pending_words.push_back(make_word(nsp_pkg::OP_EXIT, $urandom_range(31),
                                          $urandom_range(15), clock_us));
        if (depth > 0) depth--;
      end else if (pick < 98) begin
        pending_words.push_back(make_word(nsp_pkg::OP_READ, $urandom_range(id_span),
                                          $urandom_range(15), clock_us));
      end else begin
        pending_words.push_back(make_word(nsp_pkg::OP_CLEAR, $urandom_range(31),
                                          $urandom_range(15), clock_us));
      end
    end
    drain();
  endtask

  initial begin
    logic [31:0] t;
    build_bucket_bounds();
    gamma = nsp_pkg::EMA_WEIGHT_RESET;
    live_sections = '0;
    nest_level = 0;
    for (int i = 0; i < SECTIONS; i++) begin
      calls[i] = '0; exec_sum[i] = '0; child_sum[i] = '0; gap_sum[i] = '0;
      last_enter[i] = '0; exec_ema[i] = '0; gap_ema[i] = '0;
      for (int j = 0; j < HIST_BINS; j++) begin
        exec_hist[i][j] = '0;
        gap_hist[i][j] = '0;
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // With no sections registered every id is rejected; an exit finds the stack empty.
    pending_words.push_back(make_word(nsp_pkg::OP_ENTER, 0, 0, 32'd0));
    pending_words.push_back(make_word(nsp_pkg::OP_READ, 31, 15, MAX32));
    pending_words.push_back(make_word(nsp_pkg::OP_EXIT, 0, 0, 32'd5));
    drain();

    write_register(nsp_pkg::CFG_SECTIONS, 16'd32);
    write_register(nsp_pkg::CFG_EMA_WEIGHT, 16'd65535);
    // Directed: id 31, wrapped timestamps, full stack, out-of-range bucket,
    // clear while sections are open, then exits of the cleared sections.
    t = 32'hFFFF_FF00;
    for (int i = 0; i < NEST_DEPTH; i++)
      pending_words.push_back(make_word(nsp_pkg::OP_ENTER, (i == 0) ? 31 : i, i % 10,
                                        t + 32'(i * 97)));
    pending_words.push_back(make_word(nsp_pkg::OP_ENTER, 3, 0, 32'd10));
    pending_words.push_back(make_word(nsp_pkg::OP_READ, 31, 10, 32'd11));
    pending_words.push_back(make_word(nsp_pkg::OP_CLEAR, 0, 0, 32'd12));
    pending_words.push_back(make_word(nsp_pkg::OP_EXIT, 0, 9, 32'd2000000));
    pending_words.push_back(make_word(nsp_pkg::OP_EXIT, 0, 0, MAX32));
    pending_words.push_back(make_word(nsp_pkg::OP_ENTER, 31, 9, 32'd40));
    pending_words.push_back(make_word(nsp_pkg::OP_EXIT, 0, 1, 32'd45));
    pending_words.push_back(make_word(nsp_pkg::OP_ENTER, 31, 0, 32'd3000000));
    pending_words.push_back(make_word(nsp_pkg::OP_READ, 31, 9, 32'd3000001));
    drain();
    while (nest_level > 0) begin
      pending_words.push_back(make_word(nsp_pkg::OP_EXIT, 0, 0, $urandom));
      drain();
    end

    write_register(nsp_pkg::CFG_EMA_WEIGHT, 16'd0);
    random_phase(150, 31, 1'b0);
    write_register(nsp_pkg::CFG_EMA_WEIGHT, nsp_pkg::EMA_WEIGHT_RESET);
    write_register(nsp_pkg::CFG_SECTIONS, 16'd5);
    random_phase(200, 7, 1'b0);
    idle_free = 1'b1;
    write_register(nsp_pkg::CFG_SECTIONS, 16'd1);
    random_phase(100, 2, 1'b1);
    idle_free = 1'b0;
    write_register(nsp_pkg::CFG_SECTIONS, 16'd32);
    write_register(nsp_pkg::CFG_EMA_WEIGHT, 16'($urandom));
    random_phase(350, 31, 1'b0);

    $display("Sent %0d words covering enter, exit, read and clear; checked %0d results.",
             sent_words, words_checked);
    $display("Register settings spanned both ends of the weight and section count.");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
